// File: src/srsw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

   localparam int WINDOW_DEFAULT = 8;
   localparam int SEQ_W          = 16;
   localparam int TICK_W         = 32;
   localparam int DELAY_W        = 16;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd4;

   // request kinds carried on req_tuser
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ACK  = 1'b1;

   // send reasons carried on rsp_tuser
   localparam logic REASON_TIMEOUT = 1'b0;
   localparam logic REASON_NEW     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_ACK_MARK,
      ST_SLIDE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;     // latch request, start a scan at the window base
      logic tick_step;  // check one slot for timeout, advance
      logic ack_mark;   // mark the acknowledged slot
      logic slide_step; // pass one acked slot, send the packet a window ahead
      logic commit;     // move the window base to the scan position
      logic flush;      // hand the held result out as the final one
   } cmd_type;

   typedef struct packed {
      logic req_is_tick;
      logic in_window;
      logic tick_hit;
      logic slide_hit;
      logic last_step;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: src/srsw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module srsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: src/srsw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: walks a tick or an acknowledgement through the window scan and
// hands the last held result out before taking the next request.
// ----------------------------------------------------------------------------
module srsw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire srsw_pkg::status_type status,
   output srsw_pkg::cmd_type         cmd
);

   import srsw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = status.req_is_tick ? ST_TICK_RD : ST_ACK_MARK;
            end
         end
         ST_TICK_RD: begin
            state_in = ST_TICK_CHK;
         end
         ST_TICK_CHK: begin
            // hold while a new hit would need the busy output register
            if (!(status.tick_hit && status.pend_valid && !status.out_free)) begin
               cmd.tick_step = 1'b1;
               state_in      = status.last_step ? ST_FLUSH : ST_TICK_RD;
            end
         end
         ST_ACK_MARK: begin
            if (status.in_window) begin
               cmd.ack_mark = 1'b1;
               state_in     = ST_SLIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SLIDE: begin
            if (!status.slide_hit) begin
               cmd.commit = 1'b1;
               state_in   = ST_FLUSH;
            end else if (status.out_free || !status.pend_valid) begin
               cmd.slide_step = 1'b1;
               if (status.last_step) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: src/srsw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_datapath
// Window state, slot flags, deadline memory, scan position, held result and
// output register.
// ----------------------------------------------------------------------------
module srsw_datapath #(
   parameter int WINDOW = srsw_pkg::WINDOW_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [srsw_pkg::SEQ_W-1:0]    req_tdata,
   input  wire logic                          req_tuser,
   output logic      [srsw_pkg::SEQ_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic                          csr_wr_en,
   input  wire logic [srsw_pkg::DELAY_W-1:0]  csr_wr_data,
   input  wire srsw_pkg::cmd_type             cmd,
   output srsw_pkg::status_type               status
);

   import srsw_pkg::*;

   localparam int SLOTS  = 2 * WINDOW;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   localparam logic [SLOT_W:0]    SLOTS_WIDE = (SLOT_W + 1)'(SLOTS);
   localparam logic [SLOT_W:0]    WIN_WIDE   = (SLOT_W + 1)'(WINDOW);
   localparam logic [SEQ_W-1:0]   WIN_SEQ    = SEQ_W'(WINDOW);
   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(WINDOW - 1);

   // architectural state
   logic [SEQ_W-1:0]   base_ff,      base_in;
   logic [SLOT_W-1:0]  base_slot_ff, base_slot_in;
   logic [TICK_W-1:0]  tick_ff,      tick_in;
   logic [DELAY_W-1:0] delay_ff,     delay_in;
   logic [SLOTS-1:0]   acked_ff,     acked_in;
   logic [SLOTS-1:0]   dl_valid_ff,  dl_valid_in;

   // scan
   logic [SEQ_W-1:0]   scan_seq_ff,  scan_seq_in;
   logic [SLOT_W-1:0]  scan_slot_ff, scan_slot_in;
   logic [IDX_W-1:0]   idx_ff,       idx_in;
   logic [SEQ_W-1:0]   ack_ff,       ack_in;
   logic               rd_valid_ff;

   // held result and output register
   logic               pend_valid_ff,  pend_valid_in;
   logic [SEQ_W-1:0]   pend_seq_ff,    pend_seq_in;
   logic               pend_reason_ff, pend_reason_in;
   logic               out_valid_ff,   out_valid_in;
   logic [SEQ_W-1:0]   out_seq_ff,     out_seq_in;
   logic               out_reason_ff,  out_reason_in;
   logic               out_last_ff,    out_last_in;

   // deadline memory
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [TICK_W-1:0]  wr_data;
   logic [TICK_W-1:0]  rd_data;
   logic [TICK_W-1:0]  deadline;
   logic [TICK_W-1:0]  age;

   // slot arithmetic
   logic [SEQ_W-1:0]   ack_off;
   logic [SLOT_W:0]    ack_sum;
   logic [SLOT_W-1:0]  ack_slot;
   logic [SEQ_W-1:0]   nxt_seq;
   logic [SLOT_W:0]    nxt_sum;
   logic [SLOT_W-1:0]  nxt_slot;
   logic [SLOT_W-1:0]  step_slot;

   logic               emit_tick;
   logic               emit_slide;
   logic               emit;
   logic               push;
   logic               out_free;
   logic               advance;

   srsw_ram #(
      .WIDTH (TICK_W),
      .DEPTH (SLOTS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_slot_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      // slot of the acked number: below the base means it wrapped past zero
      ack_off = ack_ff - base_ff;
      ack_sum = {1'b0, base_slot_ff} + ack_off[SLOT_W:0];
      if (ack_ff < base_ff) begin
         ack_slot = ack_ff[SLOT_W-1:0];
      end else if (ack_sum >= SLOTS_WIDE) begin
         ack_slot = SLOT_W'(ack_sum - SLOTS_WIDE);
      end else begin
         ack_slot = ack_sum[SLOT_W-1:0];
      end

      // slot of the packet one window ahead of the scan position
      nxt_seq = scan_seq_ff + WIN_SEQ;
      nxt_sum = {1'b0, scan_slot_ff} + WIN_WIDE;
      if (nxt_seq < scan_seq_ff) begin
         nxt_slot = nxt_seq[SLOT_W-1:0];
      end else if (nxt_sum >= SLOTS_WIDE) begin
         nxt_slot = SLOT_W'(nxt_sum - SLOTS_WIDE);
      end else begin
         nxt_slot = nxt_sum[SLOT_W-1:0];
      end

      // slot of scan_seq + 1
      if (scan_seq_ff == '1 || scan_slot_ff == SLOT_LAST) begin
         step_slot = '0;
      end else begin
         step_slot = scan_slot_ff + 1'b1;
      end

      deadline = rd_valid_ff ? rd_data : '0;
      age      = tick_ff - deadline;
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      status.req_is_tick = (req_tuser == REQ_TICK);
      status.in_window   = (ack_off < WIN_SEQ);
      status.tick_hit    = !acked_ff[scan_slot_ff] && !age[TICK_W-1];
      status.slide_hit   = acked_ff[scan_slot_ff];
      status.last_step   = (idx_ff == IDX_LAST);
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
   end

   assign emit_tick  = cmd.tick_step && status.tick_hit;
   assign emit_slide = cmd.slide_step && status.slide_hit;
   assign emit       = emit_tick || emit_slide;
   assign push       = (emit && pend_valid_ff) || cmd.flush;
   assign advance    = cmd.tick_step || emit_slide;

   always_comb begin
      base_in      = base_ff;
      base_slot_in = base_slot_ff;
      tick_in      = tick_ff;
      delay_in     = csr_wr_en ? csr_wr_data : delay_ff;
      acked_in     = acked_ff;
      dl_valid_in  = dl_valid_ff;
      scan_seq_in  = scan_seq_ff;
      scan_slot_in = scan_slot_ff;
      idx_in       = idx_ff;
      ack_in       = ack_ff;
      wr_en        = 1'b0;
      wr_addr      = scan_slot_ff;
      wr_data      = tick_ff + {{(TICK_W - DELAY_W){1'b0}}, delay_ff};

      if (cmd.accept) begin
         ack_in       = req_tdata;
         scan_seq_in  = base_ff;
         scan_slot_in = base_slot_ff;
         idx_in       = '0;
         if (req_tuser == REQ_TICK) begin
            tick_in = tick_ff + 1'b1;
         end
      end

      if (cmd.ack_mark) begin
         acked_in[ack_slot] = 1'b1;
      end

      if (emit_tick) begin
         wr_en = 1'b1;
      end

      if (emit_slide) begin
         wr_en              = 1'b1;
         wr_addr            = nxt_slot;
         acked_in[nxt_slot] = 1'b0;
      end

      if (wr_en) begin
         dl_valid_in[wr_addr] = 1'b1;
      end

      if (advance) begin
         scan_seq_in  = scan_seq_ff + 1'b1;
         scan_slot_in = step_slot;
         idx_in       = idx_ff + 1'b1;
      end

      if (cmd.commit) begin
         base_in      = scan_seq_in;
         base_slot_in = scan_slot_in;
      end
   end

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_seq_in    = pend_seq_ff;
      pend_reason_in = pend_reason_ff;
      out_seq_in     = out_seq_ff;
      out_reason_in  = out_reason_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;

      // hold each hit back one step so the final one can carry the last flag
      if (push) begin
         out_valid_in  = 1'b1;
         out_seq_in    = pend_seq_ff;
         out_reason_in = pend_reason_ff;
         out_last_in   = cmd.flush;
      end

      if (emit) begin
         pend_valid_in  = 1'b1;
         pend_seq_in    = emit_slide ? nxt_seq : scan_seq_ff;
         pend_reason_in = emit_slide ? REASON_NEW : REASON_TIMEOUT;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         base_slot_ff  <= '0;
         tick_ff       <= '0;
         delay_ff      <= DELAY_RESET;
         acked_ff      <= '0;
         dl_valid_ff   <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         base_ff       <= base_in;
         base_slot_ff  <= base_slot_in;
         tick_ff       <= tick_in;
         delay_ff      <= delay_in;
         acked_ff      <= acked_in;
         dl_valid_ff   <= dl_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_seq_ff    <= scan_seq_in;
      scan_slot_ff   <= scan_slot_in;
      idx_ff         <= idx_in;
      ack_ff         <= ack_in;
      rd_valid_ff    <= dl_valid_ff[scan_slot_ff];
      pend_seq_ff    <= pend_seq_in;
      pend_reason_ff <= pend_reason_in;
      out_seq_ff     <= out_seq_in;
      out_reason_ff  <= out_reason_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_seq_ff;
   assign rsp_tuser  = out_reason_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// File: src/selective_repeat_sender_window.sv
`default_nettype none
// Sequence: a tick makes one memory read and one check per window slot, then
//   hands out the held result; an acknowledgement outside the window returns to idle,
//   and one inside it marks its slot and slides the window over leading acked slots.
// Throughput: one request at a time; results drain through an output register.
// Reset: synchronous; clears slot flags, deadline-valid flags, window base, tick count and
//   sets the retransmit delay to 4.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat ARQ: timeout retransmission on ticks,
// window slide and new packets on acknowledgements.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
   parameter int WINDOW = srsw_pkg::WINDOW_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [srsw_pkg::SEQ_W-1:0]    req_tdata,   // [15:0] ack_number
   input  wire logic                          req_tuser,   // [0] req_type
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [srsw_pkg::SEQ_W-1:0]    rsp_tdata,   // [15:0] send_seq
   output logic                               rsp_tuser,   // [0] send_reason
   output logic                               rsp_tlast,
   input  wire logic                          csr_wr_en,
   input  wire logic [srsw_pkg::DELAY_W-1:0]  csr_wr_data  // retransmit_delay
);

   import srsw_pkg::*;

   cmd_type    cmd;
   status_type status;

   srsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srsw_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

// File: tb/selective_repeat_sender_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_tb
// Drives timer ticks and acknowledgements into the sender window. A scoreboard
// tracks the window, per-slot acked flags and deadlines, and checks every
// send in order. The run covers directed corner cases, a stretch of
// back-to-back acknowledgements with no idling, and random phases under
// several delays.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_tb;
   import srsw_pkg::*;

   localparam int WIN        = WINDOW_DEFAULT;
   localparam int SLOTS      = 2 * WIN;
   localparam int SETTLE     = 2 * WIN + 8;
   localparam int STALL_MAX  = 5000;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic             reason;
      logic             last;
   } send_type;

   class sender_window_scoreboard;
      logic              acked_flag [SLOTS];
      logic [TICK_W-1:0] due_at [SLOTS];
      logic [SEQ_W-1:0]  win_base;
      logic [TICK_W-1:0] tick_ctr;
      logic [DELAY_W-1:0] resend_delay;
      send_type          expected_sends [$];
      int                errors;
      int                n_ticks;
      int                n_acks;
      int                n_checked;
      bit                wrapped;

      function new();
         foreach (acked_flag[k]) begin
            acked_flag[k] = 1'b0;
            due_at[k]     = '0;
         end
         win_base     = '0;
         tick_ctr     = '0;
         resend_delay = DELAY_RESET;
         errors       = 0;
         n_ticks      = 0;
         n_acks       = 0;
         n_checked    = 0;
         wrapped      = 1'b0;
      endfunction

      function void note_request(logic kind, logic [SEQ_W-1:0] ack_num);
         send_type          batch [$];
         logic [SEQ_W-1:0]  seq;
         logic [SEQ_W-1:0]  nxt;
         logic [SEQ_W-1:0]  offset;
         logic [SEQ_W-1:0]  old_base;
         logic [TICK_W-1:0] age;
         int                slot;
         int                i;
         old_base = win_base;
         if (kind == REQ_TICK) begin
            n_ticks++;
            tick_ctr++;
            for (i = 0; i < WIN; i++) begin
               seq  = win_base + i[SEQ_W-1:0];
               slot = int'(seq) % SLOTS;
               // deadline passed when the wrapped age is non-negative
               age  = tick_ctr - due_at[slot];
               if (!acked_flag[slot] && !age[TICK_W-1]) begin
                  batch.push_back('{seq, REASON_TIMEOUT, 1'b0});
                  due_at[slot] = tick_ctr + resend_delay;
               end
            end
         end else begin
            n_acks++;
            offset = ack_num - win_base;
            if (offset < WIN) begin
               acked_flag[int'(ack_num) % SLOTS] = 1'b1;
               seq = win_base;
               i   = 0;
               // slide over leading acked packets, open one new packet per slot
               while (i < WIN && acked_flag[int'(seq) % SLOTS]) begin
                  nxt  = seq + SEQ_W'(WIN);
                  slot = int'(nxt) % SLOTS;
                  acked_flag[slot] = 1'b0;
                  due_at[slot]     = tick_ctr + resend_delay;
                  batch.push_back('{nxt, REASON_NEW, 1'b0});
                  seq++;
                  i++;
               end
               win_base = seq;
            end
         end
         if (win_base < old_base)
            wrapped = 1'b1;
         if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
         foreach (batch[k])
            expected_sends.push_back(batch[k]);
      endfunction

      function void check_send(logic [SEQ_W-1:0] seq, logic reason, logic last);
         send_type want;
         n_checked++;
         if (expected_sends.size() == 0) begin
            errors++;
            $display("%0t: unexpected send seq=%h reason=%0d last=%0d",
                     $time, seq, reason, last);
            return;
         end
         want = expected_sends.pop_front();
         if (want.seq !== seq || want.reason !== reason || want.last !== last) begin
            errors++;
            $display("%0t: send mismatch: expected seq=%h reason=%0d last=%0d,",
                     $time, want.seq, want.reason, want.last);
            $display("   got seq=%h reason=%0d last=%0d", seq, reason, last);
         end
      endfunction

      function void report_leftover();
         if (expected_sends.size() != 0) begin
            errors += expected_sends.size();
            $display("%0t: %0d sends never arrived, oldest expected seq=%h reason=%0d last=%0d",
                     $time, expected_sends.size(), expected_sends[0].seq,
                     expected_sends[0].reason, expected_sends[0].last);
         end
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [SEQ_W-1:0]    req_tdata   = '0;   // [15:0] ack_number
   logic                req_tuser   = 1'b0; // [0] req_type
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [SEQ_W-1:0]    rsp_tdata;          // [15:0] send_seq
   logic                rsp_tuser;          // [0] send_reason
   logic                rsp_tlast;
   logic                csr_wr_en   = 1'b0;
   logic [DELAY_W-1:0]  csr_wr_data = '0;

   bit                  idle_on = 1'b1;
   int                  quiet_cycles = 0;
   sender_window_scoreboard sb;

   selective_repeat_sender_window #(
      .WINDOW(WIN)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= idle_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_send(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(input logic kind, input logic [SEQ_W-1:0] ack_num);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= ack_num;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(kind, ack_num);
   endtask

   // hold requests until every send is out and the block is idle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_sends.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_delay(input logic [DELAY_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.resend_delay = value;
   endtask

   task automatic run_random(input int count);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)
            send_request(REQ_TICK, SEQ_W'($urandom_range(0, 65535)));
         else if (roll < 87)
            send_request(REQ_ACK, sb.win_base + SEQ_W'($urandom_range(0, WIN - 1)));
         else
            send_request(REQ_ACK, SEQ_W'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first tick sends the whole initial window
      send_request(REQ_TICK, 16'h0000);
      send_request(REQ_ACK, 16'hFFFF);
      send_request(REQ_ACK, 16'h0008);
      send_request(REQ_ACK, 16'h0003);
      send_request(REQ_ACK, 16'h0003);
      send_request(REQ_ACK, 16'h0000);
      send_request(REQ_ACK, 16'h0001);
      send_request(REQ_ACK, 16'h0002);
      repeat (4) send_request(REQ_TICK, 16'hFFFF);
      send_request(REQ_ACK, 16'h7FFF);
      send_request(REQ_ACK, 16'h8004);

      set_delay(16'd0);
      send_request(REQ_TICK, 16'h0000);
      send_request(REQ_TICK, 16'h5A5A);
      send_request(REQ_ACK, 16'h0004);

      set_delay(16'hFFFF);
      send_request(REQ_TICK, 16'h0000);
      send_request(REQ_TICK, 16'h0000);
      send_request(REQ_ACK, 16'h0006);
      send_request(REQ_ACK, 16'h0005);
      send_request(REQ_TICK, 16'h0000);

      // ack the window base back to back with no idling on either side
      set_delay(16'd3);
      idle_on = 1'b0;
      repeat (12) send_request(REQ_ACK, sb.win_base);
      drain();
      idle_on = 1'b1;

      set_delay(16'd1);
      run_random(17);
      set_delay(DELAY_W'($urandom_range(2, 12)));
      run_random(17);
      set_delay(16'd0);
      run_random(16);
      set_delay(DELAY_W'($urandom_range(0, 65535)));
      run_random(16);

      drain();
      sb.report_leftover();
      $display("Ran %0d ticks and %0d acks, checked %0d sends;",
               sb.n_ticks, sb.n_acks, sb.n_checked);
      $display("final window base %h, wrap crossed: %0d", sb.win_base, sb.wrapped);
      $display("Retransmit delays used: 4, 0, 65535, 3, 1 and random values");
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
